[rtl/lru_ct_pkg.sv]
// Shared types and constants for the LRU cache table.
// Used by the controller, the datapath and the top level.
package lru_ct_pkg;

   // Field widths of the request and response words
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int REQ_DATA_W = KEY_W + VALUE_W;
   localparam int RSP_DATA_W = VALUE_W;

   // Request kinds carried on tuser
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the request word
      logic scan_start;  // rewind the entry scan
      logic search_en;   // scan entries for match, free slot and LRU slot
      logic decide;      // pick the slot, write key and value, read value
      logic update_en;   // scan entries and rewrite recency ranks
      logic respond;     // load the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_done;   // every entry issued and the read pipe drained
      logic need_update; // the request changes recency order
      logic out_free;    // response register can take a word
   } status_type;

endpackage

[rtl/lru_ct_controller.sv]
// Sequencer for the LRU cache table: search, decide, rank update, respond.
// Depends on lru_ct_pkg for state, command and status types.
module lru_ct_controller
   import lru_ct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.need_update) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_UPDATE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_UPDATE: begin
            cmd.update_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/lru_ct_datapath.sv]
// Entry storage, scan pipeline, slot selection and response register
// of the LRU cache table. Depends on lru_ct_pkg.
module lru_ct_datapath
   import lru_ct_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_tuser,   // action
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key [31:0], value [63:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // read_value [31:0]
   output logic                  rsp_tuser    // hit
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0] RANK_LAST = IDX_W'(ENTRIES - 1);

   // Entry memories
   logic [KEY_W-1:0]      key_mem  [ENTRIES];
   logic [IDX_W-1:0]      rank_mem [ENTRIES];
   logic [DATA_WIDTH-1:0] val_mem  [ENTRIES];

   logic [ENTRIES-1:0]    valid_ff, valid_in;

   // Captured request
   logic                  action_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [63:0]           value_wide;

   // Scan pipeline
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]      pipe_idx_ff;
   logic [IDX_W-1:0]      rd_idx;
   logic                  issue;
   logic [KEY_W-1:0]      key_rd_ff;
   logic [IDX_W-1:0]      rank_rd_ff;
   logic                  vld_rd_ff;
   logic [DATA_WIDTH-1:0] val_rd_ff;

   // Search results
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]      hit_rank_ff, hit_rank_in;
   logic                  free_ff, free_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      lru_idx_ff, lru_idx_in;

   // Chosen slot and its old rank
   logic [IDX_W-1:0]      slot_sel;
   logic [CNT_W-1:0]      old_sel;
   logic [IDX_W-1:0]      slot_ff;
   logic [CNT_W-1:0]      old_rank_ff;
   logic [IDX_W-1:0]      rank_new;
   logic                  is_put;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [63:0]           read_wide;

   assign is_put = (action_ff == ACT_PUT);
   assign rd_idx = cnt_ff[IDX_W-1:0];
   assign issue  = (cmd.search_en | cmd.update_en) && (cnt_ff != CNT_END);

   // Fit the incoming value to the stored width
   assign value_wide = {32'b0, req_tdata[REQ_DATA_W-1:KEY_W]};
   assign value_in   = value_wide[DATA_WIDTH-1:0];

   // Advance the scan counter and the read pipe
   always_comb begin
      cnt_in      = cnt_ff;
      pipe_vld_in = 1'b0;
      if (cmd.scan_start) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in      = cnt_ff + 1'b1;
         pipe_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tuser;
         key_ff    <= req_tdata[KEY_W-1:0];
         value_ff  <= value_in;
      end
   end

   // Read one entry per scan step
   always_ff @(posedge clock) begin
      if (issue) begin
         pipe_idx_ff <= rd_idx;
         key_rd_ff   <= key_mem[rd_idx];
         rank_rd_ff  <= rank_mem[rd_idx];
         vld_rd_ff   <= valid_ff[rd_idx];
      end
   end

   // Track match, highest free entry and least recent entry
   always_comb begin
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      lru_idx_in  = lru_idx_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         free_in  = 1'b0;
      end else if (cmd.search_en && pipe_vld_ff) begin
         if (vld_rd_ff && key_rd_ff == key_ff && !found_ff) begin
            found_in    = 1'b1;
            hit_idx_in  = pipe_idx_ff;
            hit_rank_in = rank_rd_ff;
         end
         if (!vld_rd_ff) begin
            free_in     = 1'b1;
            free_idx_in = pipe_idx_ff;
         end
         if (vld_rd_ff && rank_rd_ff == RANK_LAST) begin
            lru_idx_in = pipe_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         found_ff <= found_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      free_idx_ff <= free_idx_in;
      lru_idx_ff  <= lru_idx_in;
   end

   // Pick the slot: hit entry, else free entry, else evict the least recent
   always_comb begin
      if (found_ff) begin
         slot_sel = hit_idx_ff;
         old_sel  = {1'b0, hit_rank_ff};
      end else if (free_ff) begin
         slot_sel = free_idx_ff;
         old_sel  = CNT_END;
      end else begin
         slot_sel = lru_idx_ff;
         old_sel  = {1'b0, RANK_LAST};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         slot_ff     <= slot_sel;
         old_rank_ff <= old_sel;
      end
   end

   // Mark a filled entry valid
   always_comb begin
      valid_in = valid_ff;
      if (cmd.decide && is_put && !found_ff && free_ff) begin
         valid_in[free_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write key and value on a put, read value on a get hit
   always_ff @(posedge clock) begin
      if (cmd.decide && is_put) begin
         val_mem[slot_sel] <= value_ff;
         if (!found_ff) begin
            key_mem[slot_sel] <= key_ff;
         end
      end
      if (cmd.decide && !is_put && found_ff) begin
         val_rd_ff <= val_mem[hit_idx_ff];
      end
   end

   // Age entries more recent than the old rank; chosen slot becomes rank zero
   always_comb begin
      if (pipe_idx_ff == slot_ff) begin
         rank_new = '0;
      end else if (vld_rd_ff && {1'b0, rank_rd_ff} < old_rank_ff) begin
         rank_new = rank_rd_ff + 1'b1;
      end else begin
         rank_new = rank_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en && pipe_vld_ff) begin
         rank_mem[pipe_idx_ff] <= rank_new;
      end
   end

   // Response word: stored data on a get hit, zero otherwise
   assign read_wide = 64'(val_rd_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = '0;
      if (!is_put && found_ff) begin
         rsp_data_in = read_wide[RSP_DATA_W-1:0];
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_hit_ff  <= found_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // Status back to the controller
   assign status.scan_done   = (cnt_ff == CNT_END) && !pipe_vld_ff;
   assign status.need_update = found_ff | is_put;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

endmodule

[rtl/lru_cache_table_top.sv]
// Fully associative key/value store with least-recently-used replacement.
// Each request word is a get or a put (tuser) with a 32-bit key and a 32-bit
// value (tdata); each request yields one response word with the hit flag
// (tuser) and the read value (tdata), which is the stored data on a get hit
// and zero otherwise. The store starts empty after reset. One request is
// worked at a time: a scan through the entry memories, one entry per cycle,
// finds the match, the highest free entry and the least recent entry, and a
// get hit or any put is followed by a second scan that rewrites the recency
// ranks. The response sits in an output register, so the next request is
// taken while an earlier response waits.
// Depends on lru_ct_pkg, lru_ct_controller and lru_ct_datapath.
module lru_cache_table_top
   import lru_ct_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key [31:0], value [63:32]
   input  logic                  req_tuser,   // action: 0 get, 1 put
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // read_value [31:0]
   output logic                  rsp_tuser    // hit
);

   cmd_type    cmd;
   status_type status;

   lru_ct_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lru_ct_datapath #(
      .ENTRIES    (ENTRIES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[test/lru_cache_table_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lru_cache_table_top: drives get/put words, predicts
// every reply with a shadow LRU table and compares hit flag and read value.
// Depends on lru_ct_pkg and the lru_cache_table_top RTL.

import lru_ct_pkg::*;

// One expected reply word
typedef struct {
   logic               hit;
   logic [VALUE_W-1:0] read_value;
} lru_reply_t;

class lru_table_board;
   int unsigned        slots;
   bit                 slot_used[];
   logic [KEY_W-1:0]   slot_key[];
   logic [VALUE_W-1:0] slot_data[];
   int unsigned        slot_age[];
   int unsigned        fill_count;
   lru_reply_t         expected_replies[$];
   int unsigned        error_count;
   int unsigned        replies_checked;
   int unsigned        hit_count;
   int unsigned        get_count;
   int unsigned        put_count;
   int unsigned        eviction_count;

   function new(int unsigned n);
      slots = n;
      slot_used = new[n];
      slot_key = new[n];
      slot_data = new[n];
      slot_age = new[n];
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i] = '0;
         slot_data[i] = '0;
         slot_age[i] = 0;
      end
      fill_count = 0;
      error_count = 0;
      replies_checked = 0;
      hit_count = 0;
      get_count = 0;
      put_count = 0;
      eviction_count = 0;
   endfunction

   function void report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endfunction

   function int unsigned pending();
      return expected_replies.size();
   endfunction

   // Make one slot the most recent; younger entries than old_age grow older
   function void touch_slot(int unsigned slot, int unsigned old_age);
      for (int unsigned i = 0; i < slots; i++) begin
         if (slot_used[i] && i != slot && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[slot] = 0;
   endfunction

   // Predict the reply to an accepted request word and update the shadow table
   function void note_request(logic act, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int         found_at;
      int unsigned victim;
      lru_reply_t reply;
      found_at = -1;
      victim = 0;
      for (int unsigned i = 0; i < slots; i++) begin
         if (found_at < 0 && slot_used[i] && slot_key[i] == key) found_at = i;
      end
      reply.hit = (found_at >= 0);
      reply.read_value = '0;
      if (reply.hit) hit_count++;
      if (act == ACT_GET) begin
         get_count++;
         if (reply.hit) begin
            reply.read_value = slot_data[found_at];
            touch_slot(found_at, slot_age[found_at]);
         end
      end else begin
         put_count++;
         if (reply.hit) begin
            slot_data[found_at] = value;
            touch_slot(found_at, slot_age[found_at]);
         end else if (fill_count < slots) begin
            // take the highest free slot
            for (int unsigned i = 0; i < slots; i++) begin
               if (!slot_used[i]) victim = i;
            end
            slot_used[victim] = 1'b1;
            slot_key[victim] = key;
            slot_data[victim] = value;
            touch_slot(victim, slots);
            fill_count++;
         end else begin
            // reuse the least recent slot
            for (int unsigned i = 0; i < slots; i++) begin
               if (slot_used[i] && slot_age[i] == slots - 1) victim = i;
            end
            slot_key[victim] = key;
            slot_data[victim] = value;
            touch_slot(victim, slots - 1);
            eviction_count++;
         end
      end
      expected_replies.insert(expected_replies.size(), reply);
   endfunction

   // Compare a reply word with the oldest prediction
   function void check_reply(logic hit, logic [VALUE_W-1:0] read_value);
      lru_reply_t want;
      if (expected_replies.size() == 0) begin
         report($sformatf("reply hit=%0b value=%h with no request pending", hit, read_value));
         return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      if (hit !== want.hit)
         report($sformatf("reply %0d: hit %b, want %b", replies_checked, hit, want.hit));
      if (read_value !== want.read_value)
         report($sformatf("reply %0d: read_value %h, want %h",
                          replies_checked, read_value, want.read_value));
   endfunction
endclass

module lru_cache_table_top_tb;

   localparam int ENTRIES      = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int TAIL_CYCLES  = 2 * ENTRIES + 10;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_AT      = 600;
   localparam int HOLD_CYCLES  = 400;
   localparam int CHUNKS       = 12;
   localparam int CHUNK_ITEMS  = 150;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // key [31:0], value [63:32]
   logic                  req_tuser;   // action: 0 get, 1 put
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // read_value [31:0]
   logic                  rsp_tuser;   // hit

   lru_table_board board;
   int unsigned    send_gap_max;
   int unsigned    recv_gap_max;
   int unsigned    stall_cycles;
   logic [KEY_W-1:0] key_pool[32];
   int unsigned    pool_size;

   lru_cache_table_top #(
      .ENTRIES    (ENTRIES),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predict on every accepted request, check every accepted reply
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[KEY_W-1:0], req_tdata[REQ_DATA_W-1:KEY_W]);
         if (rsp_tvalid && rsp_tready)
            board.check_reply(rsp_tuser, rsp_tdata);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receive replies with random back-pressure and one long hold
   initial begin
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = (taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, recv_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   // Offer one request word and hold it until accepted
   task automatic offer_request(input logic act, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Pause the sender until every reply is back; look at the count between
   // edges so the word accepted at the last edge is already noted
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() > 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Refill the key pool: random keys and neighbors one bit apart
   task automatic refill_pool(input int unsigned n);
      pool_size = n;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 2 == 1 && $urandom_range(0, 1))
            key_pool[i] = key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
         else
            key_pool[i] = $urandom;
      end
   endtask

   task automatic random_request();
      logic               act;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      act = ($urandom_range(0, 99) < 55) ? ACT_PUT : ACT_GET;
      if ($urandom_range(0, 99) < 85)
         key = key_pool[$urandom_range(0, pool_size - 1)];
      else
         key = $urandom;
      case ($urandom_range(0, 19))
         0: value = '0;
         1: value = '1;
         default: value = $urandom;
      endcase
      offer_request(act, key, value);
   endtask

   initial begin
      board = new(ENTRIES);
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = ACT_GET;
      req_tdata = '0;
      stall_cycles = 0;
      send_gap_max = 2;
      recv_gap_max = 2;
      pool_size = 1;
      key_pool[0] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty miss, key extremes, put hit, near miss, fill and evict
      offer_request(ACT_GET, 32'h0000_0000, 32'hDEAD_BEEF);
      offer_request(ACT_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
      offer_request(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
      offer_request(ACT_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
      offer_request(ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
      offer_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
      offer_request(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(ACT_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      offer_request(ACT_GET, 32'h7FFF_FFFE, 32'h0000_0000);
      for (int i = 0; i < ENTRIES - 4; i++)
         offer_request(ACT_PUT, 32'h0000_0100 + i, $urandom);
      offer_request(ACT_PUT, 32'h0000_0200, 32'hCAFE_F00D);
      offer_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
      offer_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      offer_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);

      // Random: per chunk a new key pool and new idle limits
      for (int c = 0; c < CHUNKS; c++) begin
         refill_pool($urandom_range(6, 28));
         case ($urandom_range(0, 3))
            0: begin send_gap_max = 0;  recv_gap_max = 0;  end
            1: begin send_gap_max = 10; recv_gap_max = 0;  end
            2: begin send_gap_max = 0;  recv_gap_max = 10; end
            default: begin send_gap_max = 10; recv_gap_max = 10; end
         endcase
         if (c == 0) begin
            send_gap_max = 0;
            recv_gap_max = 0;
         end
         if (c == CHUNKS / 2) wait_drained();
         for (int i = 0; i < CHUNK_ITEMS; i++) random_request();
      end

      // Drain and let the block settle
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d gets, %0d puts: %0d hits, %0d evictions, %0d replies checked",
               board.get_count, board.put_count, board.hit_count, board.eviction_count,
               board.replies_checked);
      $display("key extremes, one-bit neighbor keys, fills, evictions and long back-pressure");
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
